>>> sv/bcc_pkg.sv
// Shared types and constants for the button click classifier.
// No dependencies; every other file of the block imports this package.
package bcc_pkg;

	// Event codes on the result channel
	localparam logic [2:0] EV_DOWN     = 3'd0;
	localparam logic [2:0] EV_END_DOWN = 3'd1;
	localparam logic [2:0] EV_SINGLE   = 3'd2;
	localparam logic [2:0] EV_DOUBLE   = 3'd3;
	localparam logic [2:0] EV_TRIPLE   = 3'd4;
	localparam logic [2:0] EV_LONG     = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HELD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP      = 3'd5;

	// Reset values of the configuration registers
	localparam logic [7:0]            RST_MASK  = 8'hFF;
	localparam logic [7:0]            RST_MODE  = 8'h00;
	localparam logic                  RST_HELD  = 1'b1;
	localparam logic [CFG_DATA_W-1:0] RST_SHORT = 16'd30;
	localparam logic [CFG_DATA_W-1:0] RST_LONG  = 16'd200;
	localparam logic [CFG_DATA_W-1:0] RST_CAP   = 16'd1000;

	// Click counter values
	localparam logic [1:0] CNT_TRIPLE = 2'd3;
	localparam logic [1:0] CNT_DOUBLE = 2'd2;
	localparam logic [1:0] CNT_STEP   = 2'd1;

	// Event queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic [2:0] idx;
		logic [2:0] code;
		logic       last;
	} bcc_event_t;

	typedef struct packed {
		logic       valid;
		bcc_event_t ev;
	} bcc_push_t;

endpackage

>>> sv/bcc_front.sv
// Front part: configuration registers, per-button state and the button sequencer.
// Walks one button per cycle, unless a full queue stalls it, and hands finished events to the queue.
// Depends on bcc_pkg.
module bcc_front #(
	parameter int BUTTON_COUNT  = 8,
	parameter int DURATION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       button_levels,
	output bcc_pkg::bcc_push_t               push,
	input  logic                             q_full
);
	import bcc_pkg::*;

	localparam int BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int CW = (DURATION_BITS > CFG_DATA_W) ? DURATION_BITS : CFG_DATA_W;
	localparam logic [CW-1:0] DMAX = CW'((64'd1 << DURATION_BITS) - 64'd1);
	localparam logic [BW-1:0] LAST_BTN = BW'(BUTTON_COUNT - 1);

	// configuration
	logic [7:0]            mask_q, mode_q;
	logic                  held_cfg_q;
	logic [CFG_DATA_W-1:0] short_q, long_q, cap_q;

	// button state
	logic [7:0]               prev_q;
	logic [1:0]               cnt_q [BUTTON_COUNT];
	logic [DURATION_BITS-1:0] dur_q [BUTTON_COUNT];
	logic                     sup_q;

	// tick under work
	logic          tick_vld_q;
	logic [7:0]    now_q;
	logic [BW-1:0] btn_q;

	// event waiting for its last flag
	logic       pend_vld_q;
	bcc_event_t pend_q;

	logic [2:0]               idx;
	logic                     held, was, en, updown;
	logic [1:0]               cnt_cur, cnt_n;
	logic [DURATION_BITS-1:0] dur_cur, dur_n;
	logic                     sup_n;
	logic                     ev_hit;
	logic [2:0]               ev_code;
	logic [CW-1:0]            cap_w;
	logic                     final_btn, push_req, step_go, mode_wr;

	assign idx       = 3'(btn_q);
	assign held      = now_q[idx];
	assign was       = prev_q[idx];
	assign en        = mask_q[idx];
	assign updown    = mode_q[idx];
	assign cnt_cur   = cnt_q[btn_q];
	assign dur_cur   = dur_q[btn_q];
	assign cap_w     = (CW'(cap_q) < DMAX) ? CW'(cap_q) : DMAX;
	assign final_btn = (btn_q == LAST_BTN);
	assign mode_wr   = cfg_wen && (cfg_index == CFG_MODE);

	always_comb begin
		cnt_n   = cnt_cur;
		dur_n   = dur_cur;
		sup_n   = sup_q;
		ev_hit  = 1'b0;
		ev_code = EV_DOWN;
		if (en) begin
			if (updown) begin
				if (held) begin
					ev_hit  = 1'b1;
					ev_code = EV_DOWN;
				end else if (was) begin
					ev_hit  = 1'b1;
					ev_code = EV_END_DOWN;
				end
			end else begin
				if (held != was) begin
					dur_n = DURATION_BITS'(1);
					if (!held) begin
						if (sup_q) begin
							sup_n = 1'b0;
							dur_n = '0;
						end else if (cnt_cur != CNT_TRIPLE) begin
							cnt_n = cnt_cur + CNT_STEP;
						end
					end
				end else if (dur_cur != '0 && CW'(dur_cur) < cap_w) begin
					dur_n = dur_cur + DURATION_BITS'(1);
				end
				priority if (cnt_n == CNT_TRIPLE) begin
					ev_hit  = 1'b1;
					ev_code = EV_TRIPLE;
					cnt_n   = '0;
					dur_n   = '0;
				end else if (CW'(dur_n) > CW'(short_q) && !held) begin
					ev_hit  = 1'b1;
					ev_code = (cnt_n == CNT_DOUBLE) ? EV_DOUBLE : EV_SINGLE;
					cnt_n   = '0;
					dur_n   = '0;
				end else if (CW'(dur_n) > CW'(long_q) && held) begin
					ev_hit  = 1'b1;
					ev_code = EV_LONG;
					cnt_n   = '0;
					dur_n   = '0;
					sup_n   = 1'b1;
				end
			end
		end
	end

	// Push the pending event once the next event or the end of its tick is known.
	assign push_req   = pend_vld_q && (pend_q.last || (tick_vld_q && ev_hit));
	assign step_go    = tick_vld_q && !(push_req && q_full);
	assign in_ready   = !tick_vld_q || (step_go && final_btn);
	assign push.valid = push_req && !q_full;
	assign push.ev    = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= RST_MASK;
			mode_q     <= RST_MODE;
			held_cfg_q <= RST_HELD;
			short_q    <= RST_SHORT;
			long_q     <= RST_LONG;
			cap_q      <= RST_CAP;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_MASK:  mask_q     <= cfg_data[7:0];
				CFG_MODE:  mode_q     <= cfg_data[7:0];
				CFG_HELD:  held_cfg_q <= cfg_data[0];
				CFG_SHORT: short_q    <= cfg_data;
				CFG_LONG:  long_q     <= cfg_data;
				CFG_CAP:   cap_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sup_q  <= 1'b0;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				cnt_q[i] <= '0;
				dur_q[i] <= '0;
			end
		end else if (mode_wr) begin
			prev_q <= '0;
			sup_q  <= !held_cfg_q;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				cnt_q[i] <= '0;
				dur_q[i] <= '0;
			end
		end else if (step_go) begin
			cnt_q[btn_q] <= cnt_n;
			dur_q[btn_q] <= dur_n;
			sup_q        <= sup_n;
			if (final_btn) begin
				prev_q <= now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_vld_q <= 1'b0;
			btn_q      <= '0;
		end else if (in_valid && in_ready) begin
			tick_vld_q <= 1'b1;
			btn_q      <= '0;
		end else if (step_go && final_btn) begin
			tick_vld_q <= 1'b0;
		end else if (step_go) begin
			btn_q <= btn_q + BW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_q <= button_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
		end else if (step_go && ev_hit) begin
			pend_vld_q  <= 1'b1;
			pend_q.idx  <= idx;
			pend_q.code <= ev_code;
			pend_q.last <= final_btn;
		end else if (push.valid) begin
			pend_vld_q <= 1'b0;
		end else if (step_go && final_btn && pend_vld_q) begin
			pend_q.last <= 1'b1;
		end
	end

endmodule

>>> sv/bcc_queue.sv
// Short event queue between the front sequencer and the output stage.
// Depends on bcc_pkg.
module bcc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  bcc_pkg::bcc_push_t  push,
	output logic                full,
	output logic                head_valid,
	output bcc_pkg::bcc_event_t head,
	input  logic                pop
);
	import bcc_pkg::*;

	bcc_event_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_pop;

	assign full       = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wp_q] <= push.ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			unique case ({push.valid, do_pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/bcc_back.sv
// Back part: output register of the result channel, fed from the event queue.
// Depends on bcc_pkg.
module bcc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  bcc_pkg::bcc_event_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          button_index,
	output logic [2:0]          event_code,
	output logic                last_event
);
	import bcc_pkg::*;

	logic       out_vld_q;
	bcc_event_t out_q;

	// Refill the register when it is empty or its request is taken.
	assign pop          = head_valid && (!out_vld_q || out_ready);
	assign out_valid    = out_vld_q;
	assign button_index = out_q.idx;
	assign event_code   = out_q.code;
	assign last_event   = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			out_vld_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

endmodule

>>> sv/button_click_classifier_unit.sv
// Top level of the button click classifier: front sequencer, event queue, output stage.
// Depends on bcc_pkg, bcc_front, bcc_queue and bcc_back.
//
//  channel  | signals                               | moves
//  ---------+---------------------------------------+-----------------------------------
//  in       | in_valid, in_ready, button_levels     | one request = one tick of 8 levels
//  out      | out_valid, out_ready, button_index,   | one request = one event, last_event
//           | event_code, last_event                | marks the final event of a tick
//  cfg      | cfg_wen, cfg_index, cfg_data          | one register write per enabled cycle
//
// The front sequencer walks a tick one button per cycle unless a full queue stalls it,
// whether or not the button raises an event; the next tick is taken on the last step.
// Events leave at one per cycle, while out_ready holds, through a 4-entry queue and the
// output register. An event is held in the front until the next event or the end of its
// tick shows whether it is the last one, and only then does it go to the queue.
// A full queue stalls the sequencer; a stalled output only fills the queue.
// Reset clears the control and per-button state at once; no clearing pass is needed.
module button_click_classifier_unit #(
	parameter int BUTTON_COUNT  = 8,
	parameter int DURATION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     button_levels,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     button_index,
	output logic [2:0]                     event_code,
	output logic                           last_event
);
	import bcc_pkg::*;

	bcc_push_t  push;
	logic       q_full;
	logic       head_valid;
	bcc_event_t head;
	logic       pop;

	// Sequence the buttons of each tick and classify them.
	bcc_front #(
		.BUTTON_COUNT  (BUTTON_COUNT),
		.DURATION_BITS (DURATION_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.button_levels (button_levels),
		.push          (push),
		.q_full        (q_full)
	);

	// Decouple the sequencer from the result channel.
	bcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Drive the result channel from a register.
	bcc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.button_index (button_index),
		.event_code   (event_code),
		.last_event   (last_event)
	);

endmodule

>>> sv/bcc_checker.sv
// Port-level checks of the button click classifier, bound to the top level.
// Depends on bcc_pkg and button_click_classifier_unit.
module bcc_checker #(
	parameter int BUTTON_COUNT = 8
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] button_index,
	input logic [2:0] event_code,
	input logic       last_event
);
	import bcc_pkg::*;

	logic       mid_tick_q;
	logic [2:0] last_idx_q;

	// Track the previous event of the tick still being delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_tick_q <= 1'b0;
			last_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			mid_tick_q <= !last_event;
			last_idx_q <= button_index;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(button_index)
			&& $stable(event_code) && $stable(last_event))
		else $error("result request changed while stalled");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= EV_LONG && int'(button_index) < BUTTON_COUNT)
		else $error("event code or button index out of range");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && mid_tick_q |-> button_index > last_idx_q)
		else $error("events of one tick not in ascending button order");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result request right after reset");

endmodule

bind button_click_classifier_unit bcc_checker #(
	.BUTTON_COUNT (BUTTON_COUNT)
) u_bcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.button_index (button_index),
	.event_code   (event_code),
	.last_event   (last_event)
);

>>> tb/sv/button_click_classifier_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for button_click_classifier_unit: directed and random button ticks,
// with a click-event scoreboard that predicts and checks every result request.
// Depends on bcc_pkg and the button_click_classifier_unit RTL.
module button_click_classifier_unit_tb;
	import bcc_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	// front walks 8 buttons per tick, then queue and output register: allow well over that
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_TICKS   = 48;
	localparam int PHASE_COUNT   = 7;
	localparam int NOISE_PCT     = 15;

	// indexes past the last register: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// directed tick sequences, first byte in the top bits
	localparam logic [95:0] CLICK_TICKS = 96'hFF00FFFFFF0000FF00FF0000;
	localparam logic [31:0] ZERO_TICKS  = 32'hA55A00FF;

	// Scoreboard: holds its own copy of configuration and per-button click history,
	// predicts the events of each accepted tick and checks results in order.
	class click_scoreboard;
		logic [7:0]  watch_mask;
		logic [7:0]  updown_mask;
		logic        held_flag;
		logic [15:0] short_to;
		logic [15:0] long_to;
		logic [15:0] dur_cap;
		logic [7:0]  last_levels;
		logic [1:0]  clicks [0:7];
		logic [15:0] held_ticks [0:7];
		logic        suppress;
		bcc_event_t  pending_events [$];
		int          errors;

		function new();
			watch_mask  = RST_MASK;
			updown_mask = RST_MODE;
			held_flag   = RST_HELD;
			short_to    = RST_SHORT;
			long_to     = RST_LONG;
			dur_cap     = RST_CAP;
			suppress    = 1'b0;
			errors      = 0;
			clear_history();
		endfunction

		function void clear_history();
			last_levels = '0;
			for (int b = 0; b < 8; b++) begin
				clicks[b]     = '0;
				held_ticks[b] = '0;
			end
		endfunction

		function void apply_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MASK:  watch_mask = data[7:0];
				CFG_MODE: begin
					updown_mask = data[7:0];
					clear_history();
					suppress = ~held_flag;
				end
				CFG_HELD:  held_flag = data[0];
				CFG_SHORT: short_to = data;
				CFG_LONG:  long_to = data;
				CFG_CAP:   dur_cap = data;
				default:   ;
			endcase
		endfunction

		// Note one accepted tick: append its events, last one marked.
		function void take_tick(input logic [7:0] lv);
			logic [7:0] toggled;
			bcc_event_t ev;
			logic       hit;
			int         first;
			toggled = lv ^ last_levels;
			first   = pending_events.size();
			for (int b = 0; b < 8; b++) begin
				ev.idx  = 3'(b);
				ev.last = 1'b0;
				if (!watch_mask[b]) begin
				end else if (updown_mask[b]) begin
					if (lv[b]) begin
						ev.code = EV_DOWN;
						pending_events.push_back(ev);
					end else if (last_levels[b]) begin
						ev.code = EV_END_DOWN;
						pending_events.push_back(ev);
					end
				end else begin
					if (toggled[b]) begin
						held_ticks[b] = 16'd1;
						if (!lv[b]) begin
							if (suppress) begin
								suppress      = 1'b0;
								held_ticks[b] = '0;
							end else if (clicks[b] != CNT_TRIPLE) begin
								clicks[b] = clicks[b] + CNT_STEP;
							end
						end
					end else if (held_ticks[b] != '0 && held_ticks[b] < dur_cap) begin
						held_ticks[b] = held_ticks[b] + 16'd1;
					end
					hit = 1'b1;
					if (clicks[b] == CNT_TRIPLE) begin
						ev.code = EV_TRIPLE;
					end else if (!lv[b] && held_ticks[b] > short_to) begin
						ev.code = (clicks[b] == CNT_DOUBLE) ? EV_DOUBLE : EV_SINGLE;
					end else if (lv[b] && held_ticks[b] > long_to) begin
						ev.code  = EV_LONG;
						suppress = 1'b1;
					end else begin
						hit = 1'b0;
					end
					if (hit) begin
						clicks[b]     = '0;
						held_ticks[b] = '0;
						pending_events.push_back(ev);
					end
				end
			end
			last_levels = lv;
			if (pending_events.size() > first)
				pending_events[pending_events.size() - 1].last = 1'b1;
		endfunction

		function void check_event(input logic [2:0] idx, input logic [2:0] code,
				input logic last);
			bcc_event_t want;
			if (pending_events.size() == 0) begin
				$error("unexpected event: button_index %0d, event_code %0d", idx, code);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			if (idx !== want.idx) begin
				$error("button_index: expected %0d, got %0d", want.idx, idx);
				errors++;
			end
			if (code !== want.code) begin
				$error("event_code: expected %0d, got %0d", want.code, code);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_event: expected %0d, got %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wen       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic [7:0]            button_levels = '0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic [2:0]            button_index;
	logic [2:0]            event_code;
	logic                  last_event;

	click_scoreboard sb;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	button_click_classifier_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.button_levels(button_levels),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.button_index (button_index),
		.event_code   (event_code),
		.last_event   (last_event)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: check each accepted event request against the oldest prediction,
	// then pick ready for the next edge. Values read here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_event(button_index, event_code, last_event);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Write one register: hold the enable for one edge, then drop it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.apply_reg(idx, data);
		@(posedge clk);
	endtask

	// Write all registers; mode goes last so its clear sees the new held flag.
	task automatic set_config(input logic [15:0] mask, input logic [15:0] mode,
			input logic [15:0] held, input logic [15:0] short_t,
			input logic [15:0] long_t, input logic [15:0] cap);
		write_reg(CFG_MASK, mask);
		write_reg(CFG_HELD, held);
		write_reg(CFG_SHORT, short_t);
		write_reg(CFG_LONG, long_t);
		write_reg(CFG_CAP, cap);
		write_reg(CFG_MODE, mode);
	endtask

	// Offer one tick request: idle at random first, then hold valid and payload
	// until the edge that accepts it. Returns right after that edge.
	task automatic push_tick(input logic [7:0] lv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		button_levels <= lv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_tick(lv);
	endtask

	// Drop valid, wait for every predicted event, then let the front finish any
	// tick that raised nothing before the registers change.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random ticks built from per-button press/release runs. Run lengths straddle
	// the short and long timeouts so single, double, triple and long clicks all
	// occur; a share of ticks is plain noise that breaks the runs.
	task automatic run_random(input int n);
		logic [7:0] levels;
		logic [7:0] lv;
		int         run_left [0:7];
		int         short_span;
		int         long_span;
		int         roll;
		short_span = (sb.short_to > 18) ? 18 : int'(sb.short_to);
		long_span  = (sb.long_to > 22) ? 22 : int'(sb.long_to);
		levels     = '0;
		for (int b = 0; b < 8; b++)
			run_left[b] = $urandom_range(3);
		repeat (n) begin
			for (int b = 0; b < 8; b++) begin
				if (run_left[b] == 0) begin
					levels[b] = ~levels[b];
					roll      = $urandom_range(99);
					if (roll < 55)
						run_left[b] = $urandom_range(2, 1);
					else if (roll < 80)
						run_left[b] = short_span + $urandom_range(2, 1);
					else
						run_left[b] = long_span + $urandom_range(2, 1);
				end
				run_left[b]--;
			end
			if ($urandom_range(99) < NOISE_PCT)
				lv = 8'($urandom);
			else
				lv = levels;
			push_tick(lv);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: three quick presses on all buttons, so the third release
		// raises a triple on every button in one tick.
		for (int k = 0; k < 7; k++)
			push_tick((k % 2 == 1) ? 8'hFF : 8'h00);
		drain();

		// Mixed modes with tiny timeouts. High data bits must be masked off; the
		// spare indexes must be ignored. Held flag 0 arms the suppress flag, so the
		// first click release is swallowed; then long, single and double clicks.
		write_reg(CFG_SPARE_LO, 16'hFFFF);
		write_reg(CFG_SPARE_HI, 16'h1234);
		set_config(16'hFFF7, 16'hFF0F, 16'hFFFE, 16'd1, 16'd2, 16'd3);
		for (int k = 0; k < 12; k++)
			push_tick(CLICK_TICKS[95 - 8 * k -: 8]);
		drain();

		// Zero timeouts and a zero cap: durations restart at 1 and never grow.
		set_config(16'h00FF, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0);
		for (int k = 0; k < 4; k++)
			push_tick(ZERO_TICKS[31 - 8 * k -: 8]);
		drain();

		// Random phases, each with its own settings and idling pattern.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			case (p)
				0: set_config(16'h00FF, 16'h0000, 16'h0001, 16'd3, 16'd8, 16'd1000);
				1: set_config(16'h00FF, 16'h00A5, 16'h0000, 16'd2, 16'd5, 16'd6);
				2: set_config(16'($urandom_range(255, 1)), 16'($urandom_range(255)),
						16'($urandom_range(1)), 16'($urandom_range(6, 1)),
						16'($urandom_range(12, 1)), 16'hFFFF);
				// largest timeouts: only triples can come out
				3: set_config(16'h00FF, 16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				// cap at 1, not above the short timeout: no single or double
				4: set_config(16'h003C, 16'h0000, 16'h0000, 16'd4, 16'd4, 16'd1);
				5: set_config(16'h00FF, 16'h00FF, 16'h0001, 16'd2, 16'd3, 16'd2);
				default: set_config(16'h007E, 16'h0081, 16'h0000, 16'd5, 16'd10, 16'd40);
			endcase
			run_random(PHASE_TICKS);
			drain();
		end

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
